>>> src/sensor_jump_fault_monitor_macros.svh
// ----------------------------------------------------------------------------
// Sensor jump fault monitor: assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_JUMP_FAULT_MONITOR_MACROS_SVH
`define SENSOR_JUMP_FAULT_MONITOR_MACROS_SVH

`ifndef SYNTH
`define SJFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sjfm assertion failed");
`define SJFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sjfm assertion failed");
`else
`define SJFM_ASSERT_NOW(lbl, ante, cons)
`define SJFM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/sjfm_pkg.sv
// ----------------------------------------------------------------------------
// Sensor jump fault monitor package
// Shared types and codes of the monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sjfm_pkg;

  localparam int unsigned CountW = 4;
  localparam int unsigned LimitW = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CountW-1:0] CountMax = 4'd15;
  localparam logic [LimitW-1:0] LimitReset = 31'd65536;

  typedef enum logic [1:0] {
    SensorLaser    = 2'd0,
    SensorAttitude = 2'd1,
    SensorBaro     = 2'd2,
    SensorUnused   = 2'd3
  } sensor_e;

  typedef enum logic [1:0] {
    FaultNone    = 2'd0,
    FaultJump    = 2'd1,
    FaultInteger = 2'd2
  } fault_code_e;

  typedef enum logic [1:0] {
    SrcNone     = 2'd0,
    SrcLaser    = 2'd1,
    SrcAttitude = 2'd2,
    SrcBaro     = 2'd3
  } fault_src_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable        = 2'd0,
    RegLaserLimit    = 2'd1,
    RegAttitudeLimit = 2'd2,
    RegPressureLimit = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              latched;
    logic [CountW-1:0] count;
    logic              seen;
  } ch_state_t;

  typedef struct packed {
    logic        forward;
    logic        store;
    logic        code_we;
    fault_code_e code;
  } judge_res_t;

endpackage

>>> src/sjfm_if.sv
// ----------------------------------------------------------------------------
// Sensor jump fault monitor channels
// Sample, result and configuration handshake interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sjfm_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     sensor;
  logic signed [SAMPLE_WIDTH-1:0] value_a;
  logic signed [SAMPLE_WIDTH-1:0] value_b;

  modport source (output valid, sensor, value_a, value_b, input ready);
  modport sink (input valid, sensor, value_a, value_b, output ready);
endinterface

interface sjfm_result_if;
  logic       valid;
  logic       ready;
  logic       forward;
  logic       laser_fault;
  logic       attitude_fault;
  logic       baro_fault;
  logic [1:0] last_fault_code;
  logic [1:0] fault_source;

  modport source (output valid, forward, laser_fault, attitude_fault, baro_fault,
                  last_fault_code, fault_source, input ready);
  modport sink (input valid, forward, laser_fault, attitude_fault, baro_fault,
                last_fault_code, fault_source, output ready);
endinterface

interface sjfm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sjfm_pkg::CfgIdxW-1:0] index;
  logic [sjfm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/sjfm_judge.sv
// ----------------------------------------------------------------------------
// Sensor jump fault monitor: sample judge
// Next state of one sensor channel from its state, last good value and sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sjfm_judge #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned ERROR_LIMIT  = 10
) (
  input  sjfm_pkg::ch_state_t                cur_i,
  input  logic                               two_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     a_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     b_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     last_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     last_b_i,
  input  logic [sjfm_pkg::LimitW-1:0]        limit_i,
  output sjfm_pkg::ch_state_t                nxt_o,
  output sjfm_pkg::judge_res_t               res_o
);

  localparam int unsigned DW = SAMPLE_WIDTH + 1;
  localparam int unsigned CW = (DW > sjfm_pkg::LimitW) ? DW : sjfm_pkg::LimitW;
  localparam logic [sjfm_pkg::CountW-1:0] Limit = sjfm_pkg::CountW'(ERROR_LIMIT);

  logic signed [DW-1:0]        diff_a, diff_b;
  logic [DW-1:0]               mag_a, mag_b;
  logic                        near, valid;
  logic [sjfm_pkg::CountW-1:0] count_inc;

  assign diff_a = {a_i[SAMPLE_WIDTH-1], a_i} - {last_a_i[SAMPLE_WIDTH-1], last_a_i};
  assign diff_b = {b_i[SAMPLE_WIDTH-1], b_i} - {last_b_i[SAMPLE_WIDTH-1], last_b_i};
  assign mag_a  = diff_a[DW-1] ? DW'(-diff_a) : DW'(diff_a);
  assign mag_b  = diff_b[DW-1] ? DW'(-diff_b) : DW'(diff_b);

  assign valid = (a_i[15:0] != 16'd0) && (!two_i || (b_i[15:0] != 16'd0));
  assign near  = (CW'(mag_a) < CW'(limit_i)) && (!two_i || (CW'(mag_b) < CW'(limit_i)));

  assign count_inc = (cur_i.count < sjfm_pkg::CountMax) ? cur_i.count + 1'b1 : cur_i.count;

  always_comb begin
    nxt_o         = cur_i;
    res_o.forward = 1'b0;
    res_o.store   = 1'b0;
    res_o.code_we = 1'b0;
    res_o.code    = valid ? sjfm_pkg::FaultJump : sjfm_pkg::FaultInteger;
    if (cur_i.latched) begin
      if (valid && near) begin
        res_o.store = 1'b1;
        if (cur_i.count != '0) begin
          nxt_o.count = cur_i.count - 1'b1;
        end
      end else begin
        nxt_o.count   = Limit;
        res_o.code_we = 1'b1;
      end
      nxt_o.latched = (nxt_o.count != '0);
    end else if (!cur_i.seen) begin
      if (valid) begin
        res_o.store   = 1'b1;
        res_o.forward = 1'b1;
        nxt_o.count   = '0;
        nxt_o.seen    = 1'b1;
      end else begin
        nxt_o.count   = count_inc;
        res_o.code_we = 1'b1;
        res_o.code    = sjfm_pkg::FaultJump;
      end
    end else if (valid && near) begin
      res_o.store   = 1'b1;
      res_o.forward = 1'b1;
      nxt_o.count   = '0;
    end else begin
      nxt_o.count   = count_inc;
      res_o.code_we = 1'b1;
      if (count_inc == Limit) begin
        nxt_o.latched = 1'b1;
      end
    end
  end

endmodule

>>> src/sensor_jump_fault_monitor.sv
// ----------------------------------------------------------------------------
// Sensor jump fault monitor
// Rejects integer-valued and jumping sensor samples and latches sensor faults.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one sample item: sensor (laser, attitude, barometer) and
//         value_a / value_b in signed Q16.16.
//   out_o carries one result item per sample: forward flag, the three latched
//         fault flags, the last fault code and the last rejected sensor.
//   cfg_i writes the enable and the three jump limits and is always ready; the user
//         writes it only while no item is in flight (not enforced by the block).
// Path: the item waits in the input register and passes through the judge
//   into the result register once that register is free or being read.
// Throughput: one item per cycle while out_o takes each result; the judge
//   reads and writes the channel state in the same cycle that the result
//   register loads, so items follow back to back.
// Reset: channel state, last good values and stored codes clear; the monitor
//   is enabled with each jump limit at 1.0.
// Stall: a held result keeps the result register; the input register still
//   takes one more item, then in_i.ready drops until out_o moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sensor_jump_fault_monitor_macros.svh"

module sensor_jump_fault_monitor #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned ERROR_LIMIT  = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sjfm_sample_if.sink     in_i,
  sjfm_result_if.source   out_o,
  sjfm_cfg_if.sink        cfg_i
);

  localparam int unsigned LW = sjfm_pkg::LimitW;

  logic                             enable_q;
  logic [LW-1:0]                    laser_lim_q, att_lim_q, baro_lim_q;

  logic                             s1_valid_q;
  sjfm_pkg::sensor_e                s1_sensor_q;
  logic signed [SAMPLE_WIDTH-1:0]   s1_a_q, s1_b_q;

  sjfm_pkg::ch_state_t              st_q [3];
  sjfm_pkg::ch_state_t              st_d [3];
  logic signed [SAMPLE_WIDTH-1:0]   lgv_q [4];
  logic signed [SAMPLE_WIDTH-1:0]   lgv_d [4];
  sjfm_pkg::fault_code_e            code_q, code_d;
  sjfm_pkg::fault_src_e             src_q, src_d;

  logic                             out_valid_q;
  logic                             fwd_q, fwd_d;

  logic                             advance, active, two;
  logic [1:0]                       ch;
  logic [1:0]                       base;
  logic [LW-1:0]                    limit;
  sjfm_pkg::ch_state_t              ch_nxt;
  sjfm_pkg::judge_res_t             res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      laser_lim_q <= sjfm_pkg::LimitReset;
      att_lim_q   <= sjfm_pkg::LimitReset;
      baro_lim_q  <= sjfm_pkg::LimitReset;
    end else if (cfg_i.valid) begin
      case (sjfm_pkg::cfg_reg_e'(cfg_i.index))
        sjfm_pkg::RegEnable:        enable_q    <= cfg_i.data[0];
        sjfm_pkg::RegLaserLimit:    laser_lim_q <= cfg_i.data[LW-1:0];
        sjfm_pkg::RegAttitudeLimit: att_lim_q   <= cfg_i.data[LW-1:0];
        sjfm_pkg::RegPressureLimit: baro_lim_q  <= cfg_i.data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_sensor_q <= sjfm_pkg::sensor_e'(in_i.sensor);
      s1_a_q      <= in_i.value_a;
      s1_b_q      <= in_i.value_b;
    end
  end

  always_comb begin
    ch    = 2'd0;
    base  = 2'd0;
    two   = 1'b0;
    limit = laser_lim_q;
    case (s1_sensor_q)
      sjfm_pkg::SensorLaser: begin
        ch    = 2'd0;
        base  = 2'd0;
        limit = laser_lim_q;
      end
      sjfm_pkg::SensorAttitude: begin
        ch    = 2'd1;
        base  = 2'd1;
        two   = 1'b1;
        limit = att_lim_q;
      end
      sjfm_pkg::SensorBaro: begin
        ch    = 2'd2;
        base  = 2'd3;
        limit = baro_lim_q;
      end
      default: ;
    endcase
  end

  assign active = advance && enable_q && (s1_sensor_q != sjfm_pkg::SensorUnused);

  sjfm_judge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ERROR_LIMIT  (ERROR_LIMIT)
  ) u_judge (
    .cur_i    (st_q[ch]),
    .two_i    (two),
    .a_i      (s1_a_q),
    .b_i      (s1_b_q),
    .last_a_i (lgv_q[base]),
    .last_b_i (lgv_q[2]),
    .limit_i  (limit),
    .nxt_o    (ch_nxt),
    .res_o    (res)
  );

  always_comb begin
    st_d   = st_q;
    lgv_d  = lgv_q;
    code_d = code_q;
    src_d  = src_q;
    fwd_d  = 1'b0;
    if (active) begin
      st_d[ch] = ch_nxt;
      fwd_d    = res.forward;
      if (res.store) begin
        lgv_d[base] = s1_a_q;
        if (two) begin
          lgv_d[2] = s1_b_q;
        end
      end
      if (res.code_we) begin
        code_d = res.code;
      end
      if (!res.forward) begin
        case (s1_sensor_q)
          sjfm_pkg::SensorLaser:    src_d = sjfm_pkg::SrcLaser;
          sjfm_pkg::SensorAttitude: src_d = sjfm_pkg::SrcAttitude;
          sjfm_pkg::SensorBaro:     src_d = sjfm_pkg::SrcBaro;
          default:                  src_d = src_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        st_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        lgv_q[i] <= '0;
      end
      code_q <= sjfm_pkg::FaultNone;
      src_q  <= sjfm_pkg::SrcNone;
    end else if (advance) begin
      st_q   <= st_d;
      lgv_q  <= lgv_d;
      code_q <= code_d;
      src_q  <= src_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_q <= fwd_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.forward         = fwd_q;
  assign out_o.laser_fault     = st_q[0].latched;
  assign out_o.attitude_fault  = st_q[1].latched;
  assign out_o.baro_fault      = st_q[2].latched;
  assign out_o.last_fault_code = code_q;
  assign out_o.fault_source    = src_q;

  `SJFM_ASSERT_NOW(a_latched_count, 1'b1, !((st_q[0].latched && st_q[0].count == '0) || (st_q[1].latched && st_q[1].count == '0) || (st_q[2].latched && st_q[2].count == '0)))
  `SJFM_ASSERT_NEXT(a_state_holds, !advance, $stable(st_q[0]) && $stable(st_q[1]) && $stable(st_q[2]) && $stable(code_q))
  `SJFM_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_i.ready)
  `SJFM_ASSERT_NEXT(a_fwd_not_latched, advance && fwd_d, out_o.valid && !out_o.forward == 1'b0)

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Sensor jump fault monitor testbench
// Drives sample items from all three sensors through the monitor, predicts
// every result item from a behavioural model of the jump and fault logic, and
// compares each result field by field under random idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [sjfm_pkg::CountW-1:0] ErrorLimit = 4'd10;
  localparam int PosLaser    = 0;
  localparam int PosPitch    = 1;
  localparam int PosRoll     = 2;
  localparam int PosPressure = 3;
  localparam int ChLaser     = 0;
  localparam int ChAttitude  = 1;
  localparam int ChBaro      = 2;

  typedef enum int {BurstGood, BurstJump, BurstInteger, BurstNoise} burst_e;

  typedef struct packed {
    logic                  forward;
    logic                  laser_fault;
    logic                  attitude_fault;
    logic                  baro_fault;
    sjfm_pkg::fault_code_e code;
    sjfm_pkg::fault_src_e  src;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  sjfm_sample_if #(.SAMPLE_WIDTH(32)) smp_if ();
  sjfm_result_if res_if ();
  sjfm_cfg_if cfg_if ();

  sensor_jump_fault_monitor i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (smp_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // monitor model state and configuration
  bit                              mon_en;
  logic [sjfm_pkg::LimitW-1:0]     lim_q[3];
  bit                              latched[3];
  logic [sjfm_pkg::CountW-1:0]     err_cnt[3];
  bit                              seen[3];
  logic signed [31:0]              good_val[4];
  sjfm_pkg::fault_code_e           code_q;
  sjfm_pkg::fault_src_e            src_q;

  outcome_t pending_results[$];
  outcome_t want;

  bit quiet;
  int holdoff_left;
  int n_errors;
  int n_items;
  int n_results;
  int n_forwarded;
  int n_latches;
  int n_clears;
  int n_settings;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic void reset_model();
    mon_en = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lim_q[i] = sjfm_pkg::LimitReset;
      latched[i] = 1'b0;
      err_cnt[i] = '0;
      seen[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) good_val[i] = '0;
    code_q = sjfm_pkg::FaultNone;
    src_q = sjfm_pkg::SrcNone;
  endfunction

  function automatic bit frac_ok(logic [31:0] v);
    return v[15:0] != 16'd0;
  endfunction

  function automatic bit near_enough(logic signed [31:0] now, logic signed [31:0] prev,
                                     logic [sjfm_pkg::LimitW-1:0] lim);
    longint d;
    d = longint'(now) - longint'(prev);
    if (d < 0) d = -d;
    return d < longint'({1'b0, lim});
  endfunction

  function automatic bit judge_channel(int ch, int base, bit pair,
                                       logic signed [31:0] a, logic signed [31:0] b);
    bit ok_val;
    bit close;
    sjfm_pkg::fault_code_e code;
    ok_val = frac_ok(a) && (!pair || frac_ok(b));
    close = near_enough(a, good_val[base], lim_q[ch]) &&
            (!pair || near_enough(b, good_val[base+1], lim_q[ch]));
    code = ok_val ? sjfm_pkg::FaultJump : sjfm_pkg::FaultInteger;
    if (latched[ch]) begin
      if (ok_val && close) begin
        good_val[base] = a;
        if (pair) good_val[base+1] = b;
        if (err_cnt[ch] != 0) err_cnt[ch]--;
      end else begin
        err_cnt[ch] = ErrorLimit;
        code_q = code;
      end
      if (err_cnt[ch] == 0) begin
        latched[ch] = 1'b0;
        n_clears++;
      end
      return 1'b0;
    end
    if (!seen[ch]) begin
      if (ok_val) begin
        good_val[base] = a;
        if (pair) good_val[base+1] = b;
        err_cnt[ch] = '0;
        seen[ch] = 1'b1;
        return 1'b1;
      end
      if (err_cnt[ch] != sjfm_pkg::CountMax) err_cnt[ch]++;
      code_q = sjfm_pkg::FaultJump;
      return 1'b0;
    end
    if (ok_val && close) begin
      good_val[base] = a;
      if (pair) good_val[base+1] = b;
      err_cnt[ch] = '0;
      return 1'b1;
    end
    if (err_cnt[ch] != sjfm_pkg::CountMax) err_cnt[ch]++;
    code_q = code;
    if (err_cnt[ch] == ErrorLimit) begin
      latched[ch] = 1'b1;
      n_latches++;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t predict_outcome(sjfm_pkg::sensor_e sel, logic [31:0] a,
                                               logic [31:0] b);
    outcome_t r;
    bit fwd;
    fwd = 1'b0;
    if (mon_en && sel != sjfm_pkg::SensorUnused) begin
      case (sel)
        sjfm_pkg::SensorLaser:    fwd = judge_channel(ChLaser, PosLaser, 1'b0, a, b);
        sjfm_pkg::SensorAttitude: fwd = judge_channel(ChAttitude, PosPitch, 1'b1, a, b);
        default:                  fwd = judge_channel(ChBaro, PosPressure, 1'b0, a, b);
      endcase
      if (!fwd) begin
        case (sel)
          sjfm_pkg::SensorLaser:    src_q = sjfm_pkg::SrcLaser;
          sjfm_pkg::SensorAttitude: src_q = sjfm_pkg::SrcAttitude;
          default:                  src_q = sjfm_pkg::SrcBaro;
        endcase
      end
    end
    r.forward = fwd;
    r.laser_fault = latched[ChLaser];
    r.attitude_fault = latched[ChAttitude];
    r.baro_fault = latched[ChBaro];
    r.code = code_q;
    r.src = src_q;
    return r;
  endfunction

  function automatic int chan_of(sjfm_pkg::sensor_e sel);
    case (sel)
      sjfm_pkg::SensorLaser:    return ChLaser;
      sjfm_pkg::SensorAttitude: return ChAttitude;
      default:                  return ChBaro;
    endcase
  endfunction

  function automatic int base_of(sjfm_pkg::sensor_e sel);
    case (sel)
      sjfm_pkg::SensorLaser:    return PosLaser;
      sjfm_pkg::SensorAttitude: return PosPitch;
      default:                  return PosPressure;
    endcase
  endfunction

  function automatic logic [31:0] near_value(logic signed [31:0] anchor,
                                             logic [sjfm_pkg::LimitW-1:0] lim, bit far);
    longint delta;
    logic [31:0] span;
    logic [31:0] v;
    if (far) begin
      delta = longint'({1'b0, lim}) + longint'($urandom_range(32'h000F_FFFF));
    end else if ($urandom_range(9) == 0) begin
      delta = (lim == 0) ? 0 : longint'({1'b0, lim}) - longint'($urandom_range(1));
    end else begin
      span = (lim > 1) ? {1'b0, lim} - 32'd1 : 32'd0;
      delta = longint'($urandom_range(span));
    end
    if ($urandom_range(1)) delta = -delta;
    v = 32'(longint'(anchor) + delta);
    if (v[15:0] == 16'd0) v[0] = 1'b1;
    return v;
  endfunction

  task automatic report_mismatch(string field, int got, int exp_v);
    $display("MISMATCH %s: got %0d, expected %0d at result %0d", field, got, exp_v, n_results);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_results++;
      if (res_if.forward === 1'b1) n_forwarded++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.forward !== want.forward)
          report_mismatch("forward", res_if.forward, want.forward);
        if (res_if.laser_fault !== want.laser_fault)
          report_mismatch("laser_fault", res_if.laser_fault, want.laser_fault);
        if (res_if.attitude_fault !== want.attitude_fault)
          report_mismatch("attitude_fault", res_if.attitude_fault, want.attitude_fault);
        if (res_if.baro_fault !== want.baro_fault)
          report_mismatch("baro_fault", res_if.baro_fault, want.baro_fault);
        if (res_if.last_fault_code !== want.code)
          report_mismatch("last_fault_code", res_if.last_fault_code, want.code);
        if (res_if.fault_source !== want.src)
          report_mismatch("fault_source", res_if.fault_source, want.src);
      end
    end
  end

  // hold off the result side while a hold-off is pending
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      res_if.ready <= 1'b0;
      holdoff_left--;
    end else if (quiet) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= 18);
    end
  end

  task automatic send_sample(sjfm_pkg::sensor_e sel, logic [31:0] a, logic [31:0] b);
    if (!quiet && $urandom_range(99) < 18) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.sensor <= sel;
    smp_if.value_a <= a;
    smp_if.value_b <= b;
    do @(posedge clk_i); while (!smp_if.ready);
    pending_results.push_back(predict_outcome(sel, a, b));
    n_items++;
  endtask

  task automatic send_burst(sjfm_pkg::sensor_e sel, burst_e kind, int len);
    logic [31:0] a;
    logic [31:0] b;
    int ch;
    int base;
    int brk;
    for (int i = 0; i < len; i++) begin
      a = $urandom;
      b = $urandom;
      if (sel != sjfm_pkg::SensorUnused && kind != BurstNoise) begin
        ch = chan_of(sel);
        base = base_of(sel);
        brk = $urandom_range(2);
        a = near_value(good_val[base], lim_q[ch],
                       kind == BurstJump && (sel != sjfm_pkg::SensorAttitude || brk != 1));
        if (sel == sjfm_pkg::SensorAttitude)
          b = near_value(good_val[base+1], lim_q[ch], kind == BurstJump && brk != 0);
        if (kind == BurstInteger) begin
          if (sel != sjfm_pkg::SensorAttitude || brk != 1) a[15:0] = '0;
          if (sel == sjfm_pkg::SensorAttitude && brk != 0) b[15:0] = '0;
        end
      end
      send_sample(sel, a, b);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    smp_if.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(sjfm_pkg::cfg_reg_e idx, logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      sjfm_pkg::RegEnable:        mon_en = d[0];
      sjfm_pkg::RegLaserLimit:    lim_q[ChLaser] = d[sjfm_pkg::LimitW-1:0];
      sjfm_pkg::RegAttitudeLimit: lim_q[ChAttitude] = d[sjfm_pkg::LimitW-1:0];
      default:                    lim_q[ChBaro] = d[sjfm_pkg::LimitW-1:0];
    endcase
  endtask

  task automatic set_config(bit en, logic [31:0] l_laser, logic [31:0] l_att,
                            logic [31:0] l_press);
    logic [31:0] en_word;
    en_word = $urandom;
    en_word[0] = en;
    write_reg(sjfm_pkg::RegEnable, en_word);
    write_reg(sjfm_pkg::RegLaserLimit, l_laser);
    write_reg(sjfm_pkg::RegAttitudeLimit, l_att);
    write_reg(sjfm_pkg::RegPressureLimit, l_press);
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(3))
      0:       return $urandom_range(32'h4000, 1);
      1:       return 32'h0001_0000;
      2:       return $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(int n);
    int stop_at;
    int r;
    sjfm_pkg::sensor_e sel;
    burst_e kind;
    int len;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      r = $urandom_range(99);
      case (r % 3)
        0:       sel = sjfm_pkg::SensorLaser;
        1:       sel = sjfm_pkg::SensorAttitude;
        default: sel = sjfm_pkg::SensorBaro;
      endcase
      if (r < 4) sel = sjfm_pkg::SensorUnused;
      r = $urandom_range(99);
      if (r < 55) begin
        kind = BurstGood;
        len = $urandom_range(12, 1);
      end else if (r < 75) begin
        kind = BurstJump;
        len = $urandom_range(14, 8);
      end else if (r < 90) begin
        kind = BurstNoise;
        len = $urandom_range(4, 1);
      end else begin
        kind = BurstInteger;
        len = $urandom_range(3, 1);
      end
      send_burst(sel, kind, len);
    end
  endtask

  // attitude errors before the first capture saturate the count, never latch
  task automatic test_before_capture();
    send_burst(sjfm_pkg::SensorAttitude, BurstInteger, 17);
    send_sample(sjfm_pkg::SensorAttitude, 32'h0000_8000, 32'hFFFF_8000);
  endtask

  task automatic test_directed();
    send_sample(sjfm_pkg::SensorLaser, 32'h0001_0000, 32'h0000_0000);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(sjfm_pkg::SensorLaser, 32'h8000_0001, 32'h7FFF_FFFF);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFF_0001, 32'h0000_0000);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFE_0001, 32'h0000_0000);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFE_0002, 32'h0000_0000);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFE_0000, 32'h0000_0000);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFE_1002, 32'h8000_0000);
    send_sample(sjfm_pkg::SensorBaro, 32'h8000_0000, 32'h0000_0000);
    send_sample(sjfm_pkg::SensorBaro, 32'hFFFF_FFFF, 32'h8000_0000);
    send_sample(sjfm_pkg::SensorBaro, 32'h0000_FFFF, 32'hFFFF_FFFF);
    send_sample(sjfm_pkg::SensorBaro, 32'h0000_8000, 32'h7FFF_FFFF);
    send_sample(sjfm_pkg::SensorAttitude, 32'h0000_9000, 32'h0001_0000);
    send_sample(sjfm_pkg::SensorAttitude, 32'h0000_9000, 32'h0001_8000);
    send_sample(sjfm_pkg::SensorAttitude, 32'h0000_A000, 32'h0000_7FFF);
    send_sample(sjfm_pkg::SensorAttitude, 32'h8000_0000, 32'h8000_0000);
    send_sample(sjfm_pkg::SensorUnused, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(sjfm_pkg::SensorUnused, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_fault_latch();
    send_burst(sjfm_pkg::SensorLaser, BurstInteger, 10);
    send_burst(sjfm_pkg::SensorLaser, BurstGood, 3);
    send_burst(sjfm_pkg::SensorLaser, BurstJump, 1);
    send_burst(sjfm_pkg::SensorLaser, BurstGood, 11);
    send_burst(sjfm_pkg::SensorBaro, BurstJump, 12);
    send_burst(sjfm_pkg::SensorBaro, BurstGood, 11);
    send_burst(sjfm_pkg::SensorAttitude, BurstInteger, 10);
    send_burst(sjfm_pkg::SensorAttitude, BurstGood, 11);
  endtask

  task automatic test_config_extremes();
    drain();
    set_config(1'b1, 32'h0, 32'h0, 32'h0);
    send_burst(sjfm_pkg::SensorLaser, BurstGood, 4);
    send_burst(sjfm_pkg::SensorAttitude, BurstGood, 4);
    send_burst(sjfm_pkg::SensorBaro, BurstGood, 4);
    drain();
    set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(sjfm_pkg::SensorLaser, 32'h8000_0001, 32'h0);
    send_sample(sjfm_pkg::SensorLaser, 32'h7FFF_FFFF, 32'h0);
    send_burst(sjfm_pkg::SensorAttitude, BurstNoise, 12);
    send_burst(sjfm_pkg::SensorBaro, BurstGood, 12);
    drain();
    set_config(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    for (int i = 0; i < 10; i++) begin
      send_burst(sjfm_pkg::SensorLaser, BurstNoise, 1);
      send_burst(sjfm_pkg::SensorAttitude, BurstJump, 1);
      send_burst(sjfm_pkg::SensorBaro, BurstInteger, 1);
    end
    drain();
    set_config(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
  endtask

  // stall the result side while items keep coming, so the input backs up
  task automatic test_backpressure();
    drain();
    quiet = 1'b1;
    holdoff_left = 120;
    send_burst(sjfm_pkg::SensorLaser, BurstGood, 12);
    send_burst(sjfm_pkg::SensorBaro, BurstJump, 8);
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random();
    run_phase(350);
    drain();
    set_config(1'b1, rand_limit(), rand_limit(), rand_limit());
    run_phase(300);
    drain();
    set_config(1'b1, $urandom_range(32'h4000, 1), $urandom_range(32'h4000, 1),
               $urandom_range(32'h4000, 1));
    run_phase(250);
    drain();
    quiet = 1'b1;
    set_config(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    run_phase(250);
    quiet = 1'b0;
    drain();
    set_config(1'b1, rand_limit(), rand_limit(), rand_limit());
    run_phase(200);
    drain();
    set_config(1'b1, 32'h0, rand_limit(), rand_limit());
    run_phase(100);
  endtask

  initial begin
    rst_ni = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.sensor = sjfm_pkg::SensorLaser;
    smp_if.value_a = '0;
    smp_if.value_b = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = sjfm_pkg::RegEnable;
    cfg_if.data = '0;
    quiet = 1'b0;
    holdoff_left = 0;
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_capture();
    test_directed();
    test_fault_latch();
    test_config_extremes();
    test_backpressure();
    test_random();
    drain();

    if (pending_results.size() != 0) begin
      $display("MISMATCH %0d results never arrived", pending_results.size());
      n_errors++;
    end
    $display("Checked %0d results for %0d sample items, %0d forwarded, over %0d settings.",
             n_results, n_items, n_forwarded, n_settings);
    $display("Sensor faults latched %0d times and cleared %0d times; %0d mismatches.",
             n_latches, n_clears, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
